>>> rtl/ttks_pkg.sv
// shared types and constants for the top-k / top-p token sampler
package ttks_pkg;

   localparam int SCORE_W  = 16;
   localparam int TOKEN_W  = 17;
   localparam int RAND_W   = 16;
   localparam int FRAC_W   = 17;
   localparam int TEMP_W   = 12;
   localparam int KEEPC_W  = 7;
   localparam int CSR_IX_W = 2;
   localparam int CSR_D_W  = 17;
   localparam int WEIGHT_W = 16;

   // register indexes
   localparam logic [CSR_IX_W-1:0] CSR_INV_TEMP  = 2'd0;
   localparam logic [CSR_IX_W-1:0] CSR_NUCLEUS   = 2'd1;
   localparam logic [CSR_IX_W-1:0] CSR_KEEP      = 2'd2;

   // per-cycle control for the cell chain
   typedef struct packed {
      logic insert;
      logic rotate;
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_RUN,
      ST_START,
      ST_PROD,
      ST_LOOK,
      ST_ACC,
      ST_NMUL,
      ST_RMUL,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PASS_TOTAL,
      PASS_CUT,
      PASS_DRAW
   } pass_type;

endpackage

>>> rtl/ttks_cell.sv
// one cell of the sorted kept-score chain
module ttks_cell
   import ttks_pkg::*;
#(
   parameter int IDX_W = 17
) (
   input  logic                      clock,
   input  cell_ctrl_type             ctrl,
   input  logic                      valid,
   input  logic signed [SCORE_W-1:0] new_score,
   input  logic [IDX_W-1:0]          new_index,
   input  logic                      prev_gt,
   input  logic signed [SCORE_W-1:0] prev_score,
   input  logic [IDX_W-1:0]          prev_index,
   input  logic signed [SCORE_W-1:0] next_score,
   input  logic [IDX_W-1:0]          next_index,
   output logic                      gt,
   output logic signed [SCORE_W-1:0] score,
   output logic [IDX_W-1:0]          index
);

   logic signed [SCORE_W-1:0] score_ff, score_in;
   logic [IDX_W-1:0]          index_ff, index_in;

   // empty cells or smaller scores give way to the new score
   assign gt = !valid || (new_score > score_ff);

   // rotate for the weighting passes, or shift in the sorted insertion
   always_comb begin
      score_in = score_ff;
      index_in = index_ff;
      priority if (ctrl.rotate) begin
         score_in = next_score;
         index_in = next_index;
      end else if (ctrl.insert && gt && !prev_gt) begin
         score_in = new_score;
         index_in = new_index;
      end else if (ctrl.insert && gt) begin
         score_in = prev_score;
         index_in = prev_index;
      end
   end

   always_ff @(posedge clock) begin
      score_ff <= score_in;
      index_ff <= index_in;
   end

   assign score = score_ff;
   assign index = index_ff;

endmodule

>>> rtl/top_k_top_p_token_sampler.sv
// top level of the top-k / top-p token sampler
// usage:
//   req_ channel carries one signed Q8.8 logit per transaction, with a last flag
//   and a Q0.16 random draw that is read only on the last transaction.
//   the vocabulary index is the arrival position within the step.
//   rsp_ channel returns one token index per step, after the last transaction.
//   csr_ port writes inv_temperature (0), nucleus_fraction (1), keep_count (2);
//   the user must write only while the block is idle, the block does not enforce it; other indexes are ignored.
// throughput: one logit per cycle while the step streams in; each accepted logit
//   that beats the last kept cell, or finds it empty, is sorted into the cell chain.
// after the last logit: with keep_count 0 the token shows in the next cycle.
//   otherwise three passes rotate the chain of kept entries, each entry taking a
//   product, a table read and an accumulate step; a start step comes before the
//   passes and the two threshold products come between them, all through the
//   single shared weight unit.
//   req_ready is low from the last logit until the token is taken.
// reset: registers return to their reset values, the kept list is empty.
// a stalled rsp_ready holds the token in its register; no input is taken.
module top_k_top_p_token_sampler
   import ttks_pkg::*;
#(
   parameter int MAX_KEEP        = 64,
   parameter int VOCAB_MAX       = 131072,
   parameter int EXP_TABLE_DEPTH = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_IX_W-1:0]       csr_index,
   input  logic [CSR_D_W-1:0]        csr_wr_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [SCORE_W-1:0] req_logit,
   input  logic                      req_last,
   input  logic [RAND_W-1:0]         req_rand_fraction,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [TOKEN_W-1:0]        rsp_token
);

   localparam int IDX_W  = (VOCAB_MAX > 2) ? $clog2(VOCAB_MAX) : 1;
   localparam int FILL_W = $clog2(MAX_KEEP + 1);
   localparam int CELL_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
   localparam int TOT_W  = WEIGHT_W + FILL_W;
   localparam int CMP_W  = TOT_W + FRAC_W;
   localparam int ROM_AW = $clog2(EXP_TABLE_DEPTH);
   localparam int X_W    = SCORE_W + TEMP_W;
   localparam int IX_W   = X_W - 10;

   typedef logic [WEIGHT_W-1:0] exp_rom_type [EXP_TABLE_DEPTH];

   // e^-(i/64) in Q0.16, from a Q0.32 recurrence
   function automatic exp_rom_type build_exp_rom();
      exp_rom_type t;
      logic [63:0] v;
      logic [63:0] w;
      v = 64'd1 << 32;
      for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
         w = (v + 64'd32768) >> 16;
         t[i] = (w > 64'd65535) ? 16'hFFFF : w[WEIGHT_W-1:0];
         v = (v * 64'd4228380000) >> 32;
      end
      return t;
   endfunction

   localparam exp_rom_type EXP_ROM = build_exp_rom();

   // configuration
   logic [TEMP_W-1:0]  inv_temp_ff;
   logic [FRAC_W-1:0]  nucleus_ff;
   logic [KEEPC_W-1:0] keep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_temp_ff <= TEMP_W'(256);
         nucleus_ff  <= FRAC_W'(65536);
         keep_ff     <= KEEPC_W'(40);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_INV_TEMP: inv_temp_ff <= csr_wr_data[TEMP_W-1:0];
            CSR_NUCLEUS:  nucleus_ff  <= csr_wr_data[FRAC_W-1:0];
            CSR_KEEP:     keep_ff     <= csr_wr_data[KEEPC_W-1:0];
            default: ;
         endcase
      end
   end

   // control and datapath registers
   state_type               state_ff, state_in;
   pass_type                pass_ff, pass_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;
   logic [IDX_W-1:0]        arrival_ff, arrival_in;
   logic signed [SCORE_W-1:0] best_score_ff, best_score_in;
   logic [IDX_W-1:0]        best_index_ff, best_index_in;
   logic [FILL_W-1:0]       cnt_ff, cnt_in;
   logic [FILL_W-1:0]       cut_ff, cut_in;
   logic                    found_ff, found_in;
   logic [TOT_W-1:0]        sum_ff, sum_in;
   logic [TOT_W-1:0]        total_ff, total_in;
   logic [TOT_W-1:0]        cut_sum_ff, cut_sum_in;
   logic [CMP_W-1:0]        thr_ff, thr_in;
   logic signed [SCORE_W-1:0] top_ff, top_in;
   logic [X_W-1:0]          x_ff, x_in;
   logic [RAND_W-1:0]       rnd_ff, rnd_in;
   logic [IDX_W-1:0]        token_ff, token_in;
   logic [WEIGHT_W-1:0]     rom_q_ff;
   logic                    oor_ff, oor_in;

   // cell chain wiring
   logic signed [SCORE_W-1:0] c_score [MAX_KEEP];
   logic [IDX_W-1:0]          c_index [MAX_KEEP];
   logic [MAX_KEEP-1:0]       c_gt;
   cell_ctrl_type             ctrl;
   logic [FILL_W-1:0]         k_eff;
   logic [FILL_W-1:0]         fill_cur;
   logic                      accept;
   logic                      ins;

   assign k_eff    = (32'(keep_ff) > MAX_KEEP) ? FILL_W'(MAX_KEEP) : FILL_W'(keep_ff);
   assign fill_cur = (fill_ff > k_eff) ? k_eff : fill_ff;
   assign accept   = req_valid && req_ready;
   assign ins      = (k_eff != '0) && c_gt[CELL_W'(k_eff - 1'b1)];

   for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
      logic                      p_gt;
      logic signed [SCORE_W-1:0] p_score, n_score;
      logic [IDX_W-1:0]          p_index, n_index;
      logic                      tail;

      assign tail = (FILL_W'(i) == fill_ff - 1'b1) || (i == MAX_KEEP - 1);
      if (i == 0) begin : g_head
         assign p_gt    = 1'b0;
         assign p_score = c_score[0];
         assign p_index = c_index[0];
      end else begin : g_body
         assign p_gt    = c_gt[i-1];
         assign p_score = c_score[i-1];
         assign p_index = c_index[i-1];
      end
      if (i == MAX_KEEP - 1) begin : g_last
         assign n_score = c_score[0];
         assign n_index = c_index[0];
      end else begin : g_mid
         assign n_score = tail ? c_score[0] : c_score[i+1];
         assign n_index = tail ? c_index[0] : c_index[i+1];
      end

      ttks_cell #(.IDX_W(IDX_W)) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .valid      (FILL_W'(i) < fill_cur),
         .new_score  (req_logit),
         .new_index  (arrival_ff),
         .prev_gt    (p_gt),
         .prev_score (p_score),
         .prev_index (p_index),
         .next_score (n_score),
         .next_index (n_index),
         .gt         (c_gt[i]),
         .score      (c_score[i]),
         .index      (c_index[i])
      );
   end

   // weight table read
   logic [IX_W-1:0] ix;
   assign ix = IX_W'(x_ff >> 10);

   always_ff @(posedge clock) begin
      rom_q_ff <= EXP_ROM[ix[ROM_AW-1:0]];
   end

   // sequencer and passes
   logic [WEIGHT_W-1:0] w;
   logic [TOT_W-1:0]    run_sum;
   logic                last_entry;
   logic                best_up;

   assign w          = oor_ff ? '0 : rom_q_ff;
   assign run_sum    = sum_ff + TOT_W'(w);
   assign last_entry = (cnt_ff == fill_ff - 1'b1);
   assign best_up    = req_logit > best_score_ff;

   always_comb begin
      state_in      = state_ff;
      pass_in       = pass_ff;
      fill_in       = fill_ff;
      arrival_in    = arrival_ff;
      best_score_in = best_score_ff;
      best_index_in = best_index_ff;
      cnt_in        = cnt_ff;
      cut_in        = cut_ff;
      found_in      = found_ff;
      sum_in        = sum_ff;
      total_in      = total_ff;
      cut_sum_in    = cut_sum_ff;
      thr_in        = thr_ff;
      top_in        = top_ff;
      x_in          = x_ff;
      rnd_in        = rnd_ff;
      token_in      = token_ff;
      oor_in        = oor_ff;
      ctrl          = '0;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;

      unique case (state_ff)
         ST_RUN: begin
            req_ready = 1'b1;
            if (accept) begin
               ctrl.insert = ins;
               fill_in = (ins && fill_cur < k_eff) ? fill_cur + 1'b1 : fill_cur;
               arrival_in = (arrival_ff == IDX_W'(VOCAB_MAX - 1)) ? '0 : arrival_ff + 1'b1;
               if (best_up) begin
                  best_score_in = req_logit;
                  best_index_in = arrival_ff;
               end
               if (req_last) begin
                  rnd_in        = req_rand_fraction;
                  token_in      = best_up ? arrival_ff : best_index_ff;
                  arrival_in    = '0;
                  best_score_in = {1'b1, {(SCORE_W-1){1'b0}}};
                  best_index_in = '0;
                  if (keep_ff == '0 || fill_in == '0) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_START;
                  end
               end
            end
         end
         ST_START: begin
            top_in   = c_score[0];
            pass_in  = PASS_TOTAL;
            cnt_in   = '0;
            sum_in   = '0;
            state_in = ST_PROD;
         end
         ST_PROD: begin
            // distance to the top score is never negative, so it is zero-extended
            x_in     = X_W'(unsigned'(SCORE_W'(top_ff - c_score[0]))) * X_W'(inv_temp_ff);
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            oor_in   = 32'(ix) >= EXP_TABLE_DEPTH;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            ctrl.rotate = 1'b1;
            sum_in      = run_sum;
            cnt_in      = cnt_ff + 1'b1;
            state_in    = ST_PROD;
            unique case (pass_ff)
               PASS_TOTAL: begin
                  if (last_entry) begin
                     total_in = run_sum;
                     state_in = ST_NMUL;
                  end
               end
               PASS_CUT: begin
                  if (!found_ff && (CMP_W'(run_sum) << 16) >= thr_ff) begin
                     found_in   = 1'b1;
                     cut_in     = cnt_ff + 1'b1;
                     cut_sum_in = run_sum;
                  end
                  if (last_entry) begin
                     if (!found_in) begin
                        cut_in     = fill_ff;
                        cut_sum_in = run_sum;
                     end
                     state_in = ST_RMUL;
                  end
               end
               default: begin
                  if (!found_ff && cnt_ff < cut_ff &&
                      ((CMP_W'(run_sum) << 16) >= thr_ff || cnt_ff == cut_ff - 1'b1)) begin
                     found_in = 1'b1;
                     token_in = c_index[0];
                  end
                  if (last_entry) begin
                     state_in = ST_DONE;
                  end
               end
            endcase
         end
         ST_NMUL: begin
            thr_in   = CMP_W'(nucleus_ff) * CMP_W'(total_ff);
            pass_in  = PASS_CUT;
            cnt_in   = '0;
            sum_in   = '0;
            found_in = 1'b0;
            state_in = ST_PROD;
         end
         ST_RMUL: begin
            thr_in   = CMP_W'(rnd_ff) * CMP_W'(cut_sum_ff);
            pass_in  = PASS_DRAW;
            cnt_in   = '0;
            sum_in   = '0;
            found_in = 1'b0;
            state_in = ST_PROD;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               fill_in  = '0;
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         fill_ff       <= '0;
         arrival_ff    <= '0;
         best_score_ff <= {1'b1, {(SCORE_W-1){1'b0}}};
         best_index_ff <= '0;
         pass_ff       <= PASS_TOTAL;
         found_ff      <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         arrival_ff    <= arrival_in;
         best_score_ff <= best_score_in;
         best_index_ff <= best_index_in;
         pass_ff       <= pass_in;
         found_ff      <= found_in;
         cnt_ff        <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cut_ff     <= cut_in;
      sum_ff     <= sum_in;
      total_ff   <= total_in;
      cut_sum_ff <= cut_sum_in;
      thr_ff     <= thr_in;
      top_ff     <= top_in;
      x_ff       <= x_in;
      rnd_ff     <= rnd_in;
      token_ff   <= token_in;
      oor_ff     <= oor_in;
   end

   assign rsp_token = TOKEN_W'(token_ff);

endmodule
